// ----- hw/rtl/base64_stream_decoder_unit_defines.svh -----
// assertion macros for the base64 decoder rtl
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define B64_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: forbidden condition");
`define B64_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication violated");
`else
`define B64_ASSERT_NEVER(label, clk, rst_n, cond)
`define B64_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/b64sd_pkg.sv -----
// types, character classes and the alphabet lookup for the base64 decoder
package b64sd_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_byte;
	} in_item_t;

	typedef struct packed {
		logic       is_status;
		logic [7:0] out_byte;
		logic       ok;
	} out_item_t;

	typedef enum logic [2:0] {
		CLS_DATA,
		CLS_BLANK,
		CLS_PAD,
		CLS_BAD,
		CLS_END
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [5:0] value;
	} q_item_t;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	function automatic q_item_t classify(input in_item_t item);
		q_item_t    r;
		logic [7:0] ch;
		logic [7:0] v;
		ch      = item.char_byte;
		v       = 8'h00;
		r.cls   = CLS_BAD;
		if (item.kind == KIND_END) begin
			r.cls = CLS_END;
		end else if (ch >= 8'h41 && ch <= 8'h5a) begin
			r.cls = CLS_DATA;
			v     = ch - 8'h41;
		end else if (ch >= 8'h61 && ch <= 8'h7a) begin
			r.cls = CLS_DATA;
			v     = ch - 8'h47;
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			r.cls = CLS_DATA;
			v     = ch + 8'h04;
		end else if (ch == 8'h2b) begin
			r.cls = CLS_DATA;
			v     = 8'd62;
		end else if (ch == 8'h2f) begin
			r.cls = CLS_DATA;
			v     = 8'd63;
		end else if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0d)) begin
			r.cls = CLS_BLANK;
		end else if (ch == 8'h3d) begin
			r.cls = CLS_PAD;
		end
		r.value = v[5:0];
		return r;
	endfunction

endpackage

// ----- hw/rtl/b64sd_front.sv -----
// front stage: accepts characters, classifies them and drops whitespace
module b64sd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  b64sd_pkg::in_item_t char_item,
	output logic                front_valid,
	input  logic                front_ready,
	output b64sd_pkg::q_item_t  front_item
);

	logic               valid_s1;
	b64sd_pkg::q_item_t item_s1;
	b64sd_pkg::q_item_t cls_item;
	logic               advance;
	logic               accept;

	assign advance    = !valid_s1 || front_ready;
	assign char_stall = !advance;
	assign accept     = char_valid && advance;
	assign cls_item   = b64sd_pkg::classify(char_item);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			// whitespace never touches the decode state, so it stops here
			valid_s1 <= accept && (cls_item.cls != b64sd_pkg::CLS_BLANK);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cls_item;
		end
	end

	assign front_valid = valid_s1;
	assign front_item  = item_s1;

endmodule

// ----- hw/rtl/b64sd_queue.sv -----
// short queue of classified characters between front and back
module b64sd_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  b64sd_pkg::q_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_take,
	output b64sd_pkg::q_item_t pop_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64sd_pkg::q_item_t entries_q [DEPTH];
	logic [PW-1:0]      wr_q;
	logic [PW-1:0]      rd_q;
	logic [CW-1:0]      cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_take && pop_valid;
	assign pop_item   = entries_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_item;
		end
	end

endmodule

// ----- hw/rtl/b64sd_back.sv -----
// back stage: bit accumulator, padding/error tracking and result register
module b64sd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_take,
	input  b64sd_pkg::q_item_t  q_item,
	output logic                res_valid,
	input  logic                res_stall,
	output b64sd_pkg::out_item_t res_item
);

	logic [11:0]          acc_q;
	logic [1:0]           pend_q;
	logic                 pad_q;
	logic                 err_q;
	logic                 res_valid_q;
	b64sd_pkg::out_item_t res_item_q;

	logic [11:0]          acc_nx;
	logic [1:0]           pend_nx;
	logic                 pad_nx;
	logic                 err_nx;
	logic                 emit;
	b64sd_pkg::out_item_t emit_item;
	logic [11:0]          acc_sh;
	logic                 take;

	// result register frees up when empty or when its transaction completes
	assign take   = q_valid && (!res_valid_q || !res_stall);
	assign q_take = take;
	assign acc_sh = {acc_q[5:0], q_item.value};

	always_comb begin
		acc_nx    = acc_q;
		pend_nx   = pend_q;
		pad_nx    = pad_q;
		err_nx    = err_q;
		emit      = 1'b0;
		emit_item = '0;
		if (q_item.cls == b64sd_pkg::CLS_END) begin
			emit            = 1'b1;
			emit_item.is_status = 1'b1;
			emit_item.ok    = !err_q;
			acc_nx          = '0;
			pend_nx         = '0;
			pad_nx          = 1'b0;
			err_nx          = 1'b0;
		end else if (!err_q) begin
			case (q_item.cls)
				b64sd_pkg::CLS_PAD: begin
					pad_nx = 1'b1;
				end
				b64sd_pkg::CLS_BAD: begin
					err_nx = 1'b1;
				end
				b64sd_pkg::CLS_DATA: begin
					if (pad_q) begin
						err_nx = 1'b1;
					end else begin
						acc_nx = acc_sh;
						// pending count in 2-bit units; 6 new bits complete a byte unless empty
						case (pend_q)
							2'd1: begin
								emit               = 1'b1;
								emit_item.out_byte = acc_sh[7:0];
								pend_nx            = 2'd0;
							end
							2'd2: begin
								emit               = 1'b1;
								emit_item.out_byte = acc_sh[9:2];
								pend_nx            = 2'd1;
							end
							2'd3: begin
								emit               = 1'b1;
								emit_item.out_byte = acc_sh[11:4];
								pend_nx            = 2'd2;
							end
							default: begin
								pend_nx = 2'd3;
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pend_q      <= '0;
			pad_q       <= 1'b0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				acc_q       <= acc_nx;
				pend_q      <= pend_nx;
				pad_q       <= pad_nx;
				err_q       <= err_nx;
				res_valid_q <= emit;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_item_q <= emit_item;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

// ----- hw/rtl/base64_stream_decoder_unit.sv -----
// top level of the streaming base64 decoder
//
//  channel | direction | handshake         | payload
//  char    | in        | char_valid/stall  | b64sd_pkg::in_item_t  (kind, char_byte)
//  res     | out       | res_valid/stall   | b64sd_pkg::out_item_t (is_status, out_byte, ok)
//
// one character or end-of-text marker per cycle while char_stall is low, set by the
// accumulator update in the back stage
// from accept to result an item passes the front register, the queue and the result register
// whitespace is dropped in the front and takes no queue slot
// arst_n clears all decode state, the queue and both valid flags
// a stalled result backs up into the queue; the char channel stalls once it is full
`include "base64_stream_decoder_unit_defines.svh"

module base64_stream_decoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  b64sd_pkg::in_item_t  char_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output b64sd_pkg::out_item_t res_item
);

	logic               front_valid;
	logic               front_ready;
	b64sd_pkg::q_item_t front_item;
	logic               q_valid;
	logic               q_take;
	b64sd_pkg::q_item_t q_item;

	b64sd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_item   (char_item),
		.front_valid (front_valid),
		.front_ready (front_ready),
		.front_item  (front_item)
	);

	b64sd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (q_valid),
		.pop_take   (q_take),
		.pop_item   (q_item)
	);

	b64sd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_item    (q_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	`B64_ASSERT_IMPLIES(a_status_byte_zero, clk, arst_n, res_valid && res_item.is_status, res_item.out_byte == 8'h00)
	`B64_ASSERT_IMPLIES(a_data_ok_zero, clk, arst_n, res_valid && !res_item.is_status, !res_item.ok)
	`B64_ASSERT_IMPLIES(a_stall_needs_held_item, clk, arst_n, char_stall, front_valid && !front_ready)
	`B64_ASSERT_NEVER(a_take_empty_queue, clk, arst_n, q_take && !q_valid)

endmodule
